FILE: rtl/core/ssvg_pkg.sv
// ----------------------------------------------------------------------------
// ssvg_pkg
// Shared types, slice tables and constants for the sprite slice vertex
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssvg_pkg;

  localparam int MAX_EXTENT    = 256;
  localparam int TEXTURE_SIZE  = 512;
  localparam int SLICE_CHOICES = 3;
  localparam int TEX_LIM       = 2 * TEXTURE_SIZE - 1;

  // divider sizes
  localparam int DIVD_W    = 15;
  localparam int DIVS_W    = 5;
  localparam int DIV_CNT_W = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVD_W - 1);

  // supported texel sizes
  localparam logic [2:0] TB_4 = 3'd4;
  localparam logic [2:0] TB_2 = 3'd2;

  // slice sizes as log2: width per entry, height per texel class and entry
  localparam logic [2:0] SLICE_WL [3]    = '{3'd7, 3'd6, 3'd5};
  localparam logic [2:0] SLICE_HL [2][3] = '{'{3'd4, 3'd5, 3'd6}, '{3'd5, 3'd6, 3'd7}};
  localparam logic [9:0] SINGLE_W [2]    = '{10'd32, 10'd32};
  localparam logic [9:0] SINGLE_H [2]    = '{10'd16, 10'd32};

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_TEXEL = 2'd1,
    STAT_NO_FIT    = 2'd2,
    STAT_TOO_LARGE = 2'd3
  } status_t;

  typedef struct packed {
    logic       found;
    logic [2:0] wl;
    logic [2:0] hl;
  } slice_sel_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic slice_sel_t slice_pick(input logic t, input logic [9:0] sw,
                                            input logic [9:0] sh);
    slice_sel_t r;
    r = '0;
    if (sw >= sh) begin
      for (int k = 0; k < SLICE_CHOICES; k++) begin
        if (!r.found && (sw >= (10'd1 << SLICE_WL[k]))) begin
          r.found = 1'b1;
          r.wl    = SLICE_WL[k];
          r.hl    = SLICE_HL[t][k];
        end
      end
    end else begin
      for (int k = SLICE_CHOICES - 1; k >= 0; k--) begin
        if (!r.found && (sh >= (10'd1 << SLICE_HL[t][k]))) begin
          r.found = 1'b1;
          r.wl    = SLICE_WL[k];
          r.hl    = SLICE_HL[t][k];
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sprite_slice_vertex_generator_unit.sv
// ----------------------------------------------------------------------------
// sprite_slice_vertex_generator_unit
// Cuts a copy request into sprite corner pairs, column by column.
// ----------------------------------------------------------------------------
// plain, degenerate and error words are registered and appear in the cycle after start
// sliced copies: two passes of the shared divider (x step, then y step), then
//   one sprite per cycle, cols*rows sprites in all
// one request at a time: start is ignored while busy
// sync reset returns the sequencer to idle and drops the strobe; no stall
`default_nettype none

module sprite_slice_vertex_generator_unit
  import ssvg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_textured,
  input  logic [2:0]         in_texel_bytes,
  input  logic [8:0]         in_src_left,
  input  logic [8:0]         in_src_top,
  input  logic [9:0]         in_src_width,
  input  logic [9:0]         in_src_height,
  input  logic signed [15:0] in_dst_left,
  input  logic signed [15:0] in_dst_top,
  input  logic [14:0]        in_dst_width,
  input  logic [14:0]        in_dst_height,
  output logic               out_valid,
  output logic [9:0]         out_tex_u_start,
  output logic [9:0]         out_tex_v_start,
  output logic [9:0]         out_tex_u_end,
  output logic [9:0]         out_tex_v_end,
  output logic signed [16:0] out_screen_x_start,
  output logic signed [16:0] out_screen_y_start,
  output logic signed [16:0] out_screen_x_end,
  output logic signed [16:0] out_screen_y_end,
  output logic [1:0]         out_status,
  output logic               out_last_sprite
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIVX = 4'b0010,
    ST_DIVY = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // request classification
  logic       accept;
  logic       t_cls;
  logic       bad_tb;
  logic       too_large;
  logic       zero_ext;
  logic       single;
  slice_sel_t sel;
  logic       go_slice;
  logic       go_plain;
  status_t    err_code;
  logic       go_err;
  logic [10:0] cols_sum, rows_sum, cols_full, rows_full;
  logic [3:0] cols_m1, rows_m1;
  logic [7:0] pw, ph;

  // held request
  logic [8:0]  sl_r, st_r;
  logic [9:0]  sw_r, sh_r;
  logic [15:0] dl_r, dt_r;
  logic [14:0] dh_r;
  logic [7:0]  pw_r, ph_r;
  logic [3:0]  cols_m1_r, rows_m1_r;
  logic [14:0] stepx_r, stepy_r;

  // walk counters
  logic [3:0]  i_r, j_r;
  logic [9:0]  u_off_r, v_off_r;
  logic [14:0] x_off_r, y_off_r;

  // output word
  logic        out_valid_r;
  logic [9:0]  u0_r, v0_r, u1_r, v1_r;
  logic [16:0] x0_r, y0_r, x1_r, y1_r;
  status_t     status_r;
  logic        last_r;

  // emit datapath
  logic [10:0] ue_sum, ve_sum;
  logic [9:0]  ue, ve;
  logic [15:0] xe_off, ye_off;
  logic        col_done;
  logic        emit_last;

  // plain datapath
  logic [10:0] pu_sum, pv_sum;
  logic [9:0]  pu_end, pv_end;

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign t_cls    = (in_texel_bytes == TB_2);
  assign bad_tb   = (in_texel_bytes != TB_4) && (in_texel_bytes != TB_2);
  assign too_large = (in_src_width > 10'(MAX_EXTENT)) || (in_src_height > 10'(MAX_EXTENT));
  assign zero_ext = (in_src_width == '0) || (in_src_height == '0);
  assign single   = (in_src_width < SINGLE_W[t_cls]) && (in_src_height < SINGLE_H[t_cls]);
  assign sel      = slice_pick(t_cls, in_src_width, in_src_height);

  always_comb begin
    go_plain = 1'b0;
    go_slice = 1'b0;
    go_err   = 1'b0;
    err_code = STAT_OK;
    if (!in_textured) begin
      go_plain = 1'b1;
    end else if (bad_tb) begin
      go_err   = 1'b1;
      err_code = STAT_BAD_TEXEL;
    end else if (too_large) begin
      go_err   = 1'b1;
      err_code = STAT_TOO_LARGE;
    end else if (zero_ext) begin
      go_plain = 1'b1;
    end else if (single || sel.found) begin
      go_slice = 1'b1;
    end else begin
      go_err   = 1'b1;
      err_code = STAT_NO_FIT;
    end
  end

  assign cols_sum  = {1'b0, in_src_width} + ((11'd1 << sel.wl) - 11'd1);
  assign rows_sum  = {1'b0, in_src_height} + ((11'd1 << sel.hl) - 11'd1);
  assign cols_full = cols_sum >> sel.wl;
  assign rows_full = rows_sum >> sel.hl;
  assign cols_m1   = single ? 4'd0 : 4'(cols_full - 11'd1);
  assign rows_m1   = single ? 4'd0 : 4'(rows_full - 11'd1);
  assign pw        = single ? in_src_width[7:0]  : (8'd1 << sel.wl);
  assign ph        = single ? in_src_height[7:0] : (8'd1 << sel.hl);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = dh_r;
    div_req.divisor  = {1'b0, rows_m1_r} + 5'd1;
    if (state_r == ST_IDLE) begin
      div_req.start    = accept && go_slice;
      div_req.dividend = in_dst_width;
      div_req.divisor  = {1'b0, cols_m1} + 5'd1;
    end else if (state_r == ST_DIVX) begin
      div_req.start = div_rsp.done;
    end
  end

  ssvg_div_unit u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign ue_sum    = {1'b0, u_off_r} + {3'b000, pw_r};
  assign ve_sum    = {1'b0, v_off_r} + {3'b000, ph_r};
  assign ue        = (ue_sum > {1'b0, sw_r}) ? sw_r : ue_sum[9:0];
  assign ve        = (ve_sum > {1'b0, sh_r}) ? sh_r : ve_sum[9:0];
  assign xe_off    = {1'b0, x_off_r} + {1'b0, stepx_r};
  assign ye_off    = {1'b0, y_off_r} + {1'b0, stepy_r};
  assign col_done  = (j_r == rows_m1_r);
  assign emit_last = col_done && (i_r == cols_m1_r);

  assign pu_sum = {2'b00, in_src_left} + {1'b0, in_src_width};
  assign pv_sum = {2'b00, in_src_top} + {1'b0, in_src_height};
  assign pu_end = (pu_sum > 11'(TEX_LIM)) ? 10'(TEX_LIM) : pu_sum[9:0];
  assign pv_end = (pv_sum > 11'(TEX_LIM)) ? 10'(TEX_LIM) : pv_sum[9:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && go_slice) begin
          state_nxt = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (div_rsp.done) begin
          state_nxt = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_rsp.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ((state_r == ST_IDLE) && accept && !go_slice) || (state_r == ST_EMIT);
    end
  end

  // request capture and walk
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && accept) begin
      sl_r      <= in_src_left;
      st_r      <= in_src_top;
      sw_r      <= in_src_width;
      sh_r      <= in_src_height;
      dl_r      <= in_dst_left;
      dt_r      <= in_dst_top;
      dh_r      <= in_dst_height;
      pw_r      <= pw;
      ph_r      <= ph;
      cols_m1_r <= cols_m1;
      rows_m1_r <= rows_m1;
    end
    if ((state_r == ST_DIVX) && div_rsp.done) begin
      stepx_r <= div_rsp.quotient;
    end
    if ((state_r == ST_DIVY) && div_rsp.done) begin
      stepy_r <= div_rsp.quotient;
      i_r     <= '0;
      j_r     <= '0;
      u_off_r <= '0;
      v_off_r <= '0;
      x_off_r <= '0;
      y_off_r <= '0;
    end
    if (state_r == ST_EMIT) begin
      if (col_done) begin
        i_r     <= i_r + 4'd1;
        j_r     <= '0;
        u_off_r <= u_off_r + {2'b00, pw_r};
        v_off_r <= '0;
        x_off_r <= x_off_r + stepx_r;
        y_off_r <= '0;
      end else begin
        j_r     <= j_r + 4'd1;
        v_off_r <= v_off_r + {2'b00, ph_r};
        y_off_r <= y_off_r + stepy_r;
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT) begin
      u0_r     <= 10'({1'b0, sl_r} + u_off_r);
      v0_r     <= 10'({1'b0, st_r} + v_off_r);
      u1_r     <= 10'({1'b0, sl_r} + ue);
      v1_r     <= 10'({1'b0, st_r} + ve);
      x0_r     <= {dl_r[15], dl_r} + {2'b00, x_off_r};
      y0_r     <= {dt_r[15], dt_r} + {2'b00, y_off_r};
      x1_r     <= {dl_r[15], dl_r} + {1'b0, xe_off};
      y1_r     <= {dt_r[15], dt_r} + {1'b0, ye_off};
      status_r <= STAT_OK;
      last_r   <= emit_last;
    end else if ((state_r == ST_IDLE) && accept && go_plain) begin
      u0_r     <= {1'b0, in_src_left};
      v0_r     <= {1'b0, in_src_top};
      u1_r     <= pu_end;
      v1_r     <= pv_end;
      x0_r     <= {in_dst_left[15], in_dst_left};
      y0_r     <= {in_dst_top[15], in_dst_top};
      x1_r     <= {in_dst_left[15], in_dst_left} + {2'b00, in_dst_width};
      y1_r     <= {in_dst_top[15], in_dst_top} + {2'b00, in_dst_height};
      status_r <= STAT_OK;
      last_r   <= 1'b1;
    end else if ((state_r == ST_IDLE) && accept && go_err) begin
      u0_r     <= '0;
      v0_r     <= '0;
      u1_r     <= '0;
      v1_r     <= '0;
      x0_r     <= '0;
      y0_r     <= '0;
      x1_r     <= '0;
      y1_r     <= '0;
      status_r <= err_code;
      last_r   <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tex_u_start    = u0_r;
  assign out_tex_v_start    = v0_r;
  assign out_tex_u_end      = u1_r;
  assign out_tex_v_end      = v1_r;
  assign out_screen_x_start = x0_r;
  assign out_screen_y_start = y0_r;
  assign out_screen_x_end   = x1_r;
  assign out_screen_y_end   = y1_r;
  assign out_status         = status_r;
  assign out_last_sprite    = last_r;

endmodule

`default_nettype wire

FILE: rtl/core/ssvg_div_unit.sv
// ----------------------------------------------------------------------------
// ssvg_div_unit
// Restoring divider, one quotient bit per cycle; shared for both axis steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ssvg_div_unit
  import ssvg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVS_W-1:0]    rem_r;
  logic [DIVS_W-1:0]    dvs_r;
  logic [DIVD_W-1:0]    quo_r;
  logic [DIVS_W:0]      shifted;
  logic [DIVS_W:0]      diff;
  logic                 ge;

  assign shifted = {rem_r, quo_r[DIVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = ~diff[DIVS_W];

  assign rsp.done     = busy_r && (cnt_r == DIV_LAST);
  assign rsp.quotient = {quo_r[DIVD_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
      quo_r <= {quo_r[DIVD_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ssvg_checker.sv
// ----------------------------------------------------------------------------
// ssvg_port_checks
// Port-level checks for the sprite slice vertex generator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ssvg_port_checks
  import ssvg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_textured,
  input  logic [2:0]         in_texel_bytes,
  input  logic [8:0]         in_src_left,
  input  logic [8:0]         in_src_top,
  input  logic [9:0]         in_src_width,
  input  logic [9:0]         in_src_height,
  input  logic signed [15:0] in_dst_left,
  input  logic signed [15:0] in_dst_top,
  input  logic [14:0]        in_dst_width,
  input  logic [14:0]        in_dst_height,
  input  logic               out_valid,
  input  logic [9:0]         out_tex_u_start,
  input  logic [9:0]         out_tex_v_start,
  input  logic [9:0]         out_tex_u_end,
  input  logic [9:0]         out_tex_v_end,
  input  logic signed [16:0] out_screen_x_start,
  input  logic signed [16:0] out_screen_y_start,
  input  logic signed [16:0] out_screen_x_end,
  input  logic signed [16:0] out_screen_y_end,
  input  logic [1:0]         out_status,
  input  logic               out_last_sprite
);

  // error word ends the request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> out_last_sprite)
    else $error("error word without last flag");

  // error word carries no corners
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |->
      ((out_tex_u_start == '0) && (out_tex_v_end == '0) &&
       (out_screen_x_start == '0) && (out_screen_y_end == '0)))
    else $error("error word with nonzero corners");

  // plain copy gives its single word next cycle
  a_plain_one: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_textured) |=> (out_valid && out_last_sprite))
    else $error("plain copy word missing");

  // unsupported texel size reported next cycle
  a_bad_texel: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_textured && (in_texel_bytes != TB_4) &&
     (in_texel_bytes != TB_2)) |=> (out_valid && (out_status == STAT_BAD_TEXEL)))
    else $error("bad texel size not reported");

  // block is free once the last word is shown
  a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_sprite) |-> !busy)
    else $error("busy after last word");

endmodule

bind sprite_slice_vertex_generator_unit ssvg_port_checks u_ssvg_port_checks (.*);

`default_nettype wire
